// ===== rtl/voa_pkg.sv =====
// voa_pkg: widths, constants and side-band types for the octant heading block
// used by voa_divider and vector_to_angle_octant; no dependencies
package voa_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned QUOT_W    = FRAC_W + 1;  // ratio spans 0 to 1.0 inclusive
  localparam int unsigned HEADING_W = 14;
  localparam int unsigned HEAD_LSB  = 5;
  localparam int unsigned DIFF_W    = HEAD_LSB + HEADING_W;

  localparam logic [QUOT_W-1:0] ONE_16  = QUOT_W'(17'h10000);
  localparam logic [DIFF_W-1:0] TWO_16  = DIFF_W'(19'h20000);

  typedef logic [2:0] octant_t;

  typedef struct packed {
    octant_t octant;
    logic    zero;
  } tag_t;

endpackage

// ===== rtl/voa_if.sv =====
// voa_if: valid/ready channels for direction vectors and headings
// depends on voa_pkg for field widths
interface voa_vec_if;
  logic                                valid;
  logic                                ready;
  logic signed [voa_pkg::COORD_W-1:0]  vec_x;
  logic signed [voa_pkg::COORD_W-1:0]  vec_z;

  modport source (output valid, vec_x, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_z, output ready);
endinterface

interface voa_heading_if;
  logic                             valid;
  logic                             ready;
  logic [voa_pkg::HEADING_W-1:0]    heading;

  modport source (output valid, heading, input ready);
  modport sink   (input valid, heading, output ready);
endinterface

// ===== rtl/voa_divider.sv =====
// voa_divider: pipelined restoring divider, one quotient bit per stage
// computes (num << 16) / den for num <= den; depends on voa_pkg
module voa_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [voa_pkg::MAG_W-1:0]    num,
  input  logic [voa_pkg::MAG_W-1:0]    den,
  input  voa_pkg::tag_t                tag_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [voa_pkg::QUOT_W-1:0]   quot,
  output voa_pkg::tag_t                tag_out
);

  localparam int unsigned STAGES = voa_pkg::QUOT_W;
  localparam int unsigned MW     = voa_pkg::MAG_W;
  localparam int unsigned QW     = voa_pkg::QUOT_W;

  logic                v   [STAGES];
  logic [MW-1:0]       rem [STAGES];
  logic [MW-1:0]       dvs [STAGES];
  logic [QW-1:0]       q   [STAGES];
  voa_pkg::tag_t       tag [STAGES];
  logic                en  [STAGES];

  // stall chain: a stage moves when empty or when the next one moves
  generate
    for (genvar k = 0; k < STAGES; k++) begin : g_en
      if (k == STAGES - 1) begin : g_last
        assign en[k] = !v[k] || out_ready;
      end else begin : g_mid
        assign en[k] = !v[k] || en[k+1];
      end
    end
  endgenerate

  assign in_ready = en[0];

  generate
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic          src_v;
      logic [MW:0]   src_rem;
      logic [MW-1:0] src_dvs;
      logic [QW-1:0] src_q;
      voa_pkg::tag_t src_tag;
      logic [MW:0]   trial;
      logic          ge;

      if (k == 0) begin : g_first
        // top quotient bit: set only when num equals den
        assign src_v   = in_valid;
        assign src_rem = {1'b0, num};
        assign src_dvs = den;
        assign src_q   = '0;
        assign src_tag = tag_in;
      end else begin : g_rest
        assign src_v   = v[k-1];
        assign src_rem = {rem[k-1], 1'b0};
        assign src_dvs = dvs[k-1];
        assign src_q   = q[k-1];
        assign src_tag = tag[k-1];
      end

      assign trial = src_rem - {1'b0, src_dvs};
      assign ge    = !trial[MW];

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= ge ? trial[MW-1:0] : src_rem[MW-1:0];
          dvs[k] <= src_dvs;
          q[k]   <= {src_q[QW-2:0], ge};
          tag[k] <= src_tag;
        end
      end
    end
  endgenerate

  assign out_valid = v[STAGES-1];
  assign quot      = q[STAGES-1];
  assign tag_out   = tag[STAGES-1];

endmodule

// ===== rtl/vector_to_angle_octant.sv =====
// vector_to_angle_octant: top level of the octant heading pipeline
// depends on voa_pkg, voa_if and voa_divider
//
// Takes a direction (vec_x, vec_z) in signed 16.16 fixed point on the vec
// channel and returns a 14-bit heading (16384 per turn, 0 along +z) on the
// angle channel, one result per vector, in order. Both channels use
// valid/ready; a transfer happens on a clock edge with both high.
// The pipeline is one classify stage (signs, magnitudes, octant, operand
// swap), 17 divider stages that each resolve one quotient bit, and one
// output stage that folds the ratio into the heading: 19 register stages.
// One vector can enter every cycle while the angle receiver does not
// stall; throughput is one per cycle, set by the one-bit-per-stage
// divider pipeline.
// Each stage holds its item while the stage after it is full and stalled,
// so a stalled receiver fills the pipeline and then drops vec.ready; empty
// stages keep accepting. Nothing is lost or repeated across a stall.
// Reset (synchronous, active high) clears every valid bit; there is no
// other state and no configuration.
module vector_to_angle_octant (
  input  logic                  clk,
  input  logic                  rst,
  voa_vec_if.sink               vec,
  voa_heading_if.source         angle
);

  localparam int unsigned MW = voa_pkg::MAG_W;
  localparam int unsigned QW = voa_pkg::QUOT_W;
  localparam int unsigned DW = voa_pkg::DIFF_W;

  // classify stage
  logic            x_neg, z_neg, signs_diff, lt, swap;
  logic [MW-1:0]   ax, az;
  logic [2:0]      oct_plus3;
  voa_pkg::tag_t   f_tag_next;

  logic            f_v;
  logic [MW-1:0]   f_num, f_den;
  voa_pkg::tag_t   f_tag;
  logic            f_en;

  logic            d_in_ready, d_out_valid, d_out_ready;
  logic [QW-1:0]   d_quot;
  voa_pkg::tag_t   d_tag;

  always_comb begin
    x_neg      = vec.vec_x[MW-1];
    z_neg      = vec.vec_z[MW-1];
    signs_diff = x_neg ^ z_neg;
    ax         = x_neg ? (MW'(0) - MW'(vec.vec_x)) : MW'(vec.vec_x);
    az         = z_neg ? (MW'(0) - MW'(vec.vec_z)) : MW'(vec.vec_z);
    lt         = ax < az;
    f_tag_next.octant = {z_neg, signs_diff, lt ? !signs_diff : signs_diff};
    f_tag_next.zero   = (vec.vec_x == '0) && (vec.vec_z == '0);
    // octants 0, 3, 4 and 7 divide z by x
    oct_plus3  = f_tag_next.octant + 3'd3;
    swap       = oct_plus3[1];
  end

  assign f_en      = !f_v || d_in_ready;
  assign vec.ready = f_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (f_en) begin
      f_v <= vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_num <= swap ? az : ax;
      f_den <= swap ? ax : az;
      f_tag <= f_tag_next;
    end
  end

  voa_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_v),
    .in_ready  (d_in_ready),
    .num       (f_num),
    .den       (f_den),
    .tag_in    (f_tag),
    .out_valid (d_out_valid),
    .out_ready (d_out_ready),
    .quot      (d_quot),
    .tag_out   (d_tag)
  );

  // output stage
  logic [QW-1:0]   ratio;
  logic [DW-1:0]   diff;
  logic            o_v;
  logic [voa_pkg::HEADING_W-1:0] heading;
  logic            o_en;

  always_comb begin
    ratio = d_tag.octant[0] ? (voa_pkg::ONE_16 - d_quot) : d_quot;
    // only bits 18:5 of the 19-bit difference are kept
    diff  = voa_pkg::TWO_16
          - ({d_tag.octant, 16'h0000} + DW'(ratio));
  end

  assign o_en        = !o_v || angle.ready;
  assign d_out_ready = o_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_en) begin
      o_v <= d_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      heading <= d_tag.zero ? '0 : diff[DW-1:voa_pkg::HEAD_LSB];
    end
  end

  assign angle.valid   = o_v;
  assign angle.heading = heading;

endmodule
